// ----- rtl/ultrasonic_echo_ranger_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define UER_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic_echo_ranger: assertion failed");

// Next-cycle implication, off while reset is held.
`define UER_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ultrasonic_echo_ranger: assertion failed");

// Checked at the clock edge after every edge at which reset is held.
`define UER_ASSERT_RST(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("ultrasonic_echo_ranger: assertion failed");

`endif

// ----- rtl/uer_pkg.sv -----
package uer_pkg;

  localparam int TS_W      = 32;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int DIST_W    = 19;

  localparam logic KIND_POLL = 1'b0;
  localparam logic KIND_EDGE = 1'b1;

  localparam logic [CFG_W-1:0]  STEP_TIME_RESET     = 32'd60000;
  localparam logic [CFG_W-1:0]  MAX_STEP_TIME_RESET = 32'd100000;
  localparam logic [DIST_W-1:0] DIST_RESET          = 19'd102400;
  localparam logic [DIST_W-1:0] DIST_MAX            = 19'd524287;

  // distance = round(width * 13612 / 3125), widths above the limit saturate
  localparam int WIDTH_LIMIT = 200000;
  localparam int MEAS_W      = 18;
  localparam int PROD_W      = 32;
  localparam logic [PROD_W-1:0] SCALE_NUM  = 32'd13612;
  localparam logic [PROD_W-1:0] SCALE_BIAS = 32'd1562;
  // ceil(2^44 / 3125): exact quotient for every 32-bit dividend
  localparam int RECIP_W     = 33;
  localparam logic [RECIP_W-1:0] RECIP = 33'd5629499535;
  localparam int RECIP_SHIFT = 44;
  localparam int QUOT_W      = 20;
  localparam int RPROD_W     = PROD_W + RECIP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_TIME     = 2'd0,
    CFG_MAX_STEP_TIME = 2'd1,
    CFG_MAX_DISTANCE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DOP_KEEP = 2'd0,
    DOP_LOAD = 2'd1,
    DOP_MEAS = 2'd2
  } dist_op_t;

  typedef struct packed {
    logic [CFG_W-1:0]  step_time;
    logic [CFG_W-1:0]  max_step_time;
    logic [DIST_W-1:0] max_distance;
  } cfg_t;

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] ts;
    logic            level;
  } item_t;

  typedef struct packed {
    dist_op_t          op;
    logic [DIST_W-1:0] load_val;
    logic [MEAS_W-1:0] meas_w;
    logic              sat;
  } dist_req_t;

  typedef struct packed {
    logic      trig;
    logic      newf;
    dist_req_t drq;
  } step_res_t;

  typedef struct packed {
    logic ld_mid;
    logic ld_out;
  } pipe_en_t;

endpackage

// ----- rtl/uer_if.sv -----
interface uer_in_if;
  import uer_pkg::*;
  logic            valid;
  logic            ready;
  logic            kind;
  logic [TS_W-1:0] timestamp;
  logic            echo_level;
  modport source (output valid, output kind, output timestamp, output echo_level,
                  input ready);
  modport sink   (input valid, input kind, input timestamp, input echo_level,
                  output ready);
endinterface

interface uer_out_if;
  import uer_pkg::*;
  logic              valid;
  logic              ready;
  logic              trigger_pulse;
  logic              has_new_distance;
  logic [DIST_W-1:0] distance;
  modport source (output valid, output trigger_pulse, output has_new_distance,
                  output distance, input ready);
  modport sink   (input valid, input trigger_pulse, input has_new_distance,
                  input distance, output ready);
endinterface

interface uer_cfg_if;
  import uer_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/uer_cfg.sv -----
module uer_cfg
  import uer_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  uer_cfg_if.sink   cfg_if,
  output cfg_t      cfg
);

  cfg_t cfg_r;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.step_time     <= STEP_TIME_RESET;
      cfg_r.max_step_time <= MAX_STEP_TIME_RESET;
      cfg_r.max_distance  <= DIST_RESET;
    end else if (cfg_if.valid) begin
      case (cfg_idx_t'(cfg_if.index))
        CFG_STEP_TIME:     cfg_r.step_time     <= cfg_if.data;
        CFG_MAX_STEP_TIME: cfg_r.max_step_time <= cfg_if.data;
        CFG_MAX_DISTANCE:  cfg_r.max_distance  <= cfg_if.data[DIST_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/uer_core.sv -----
module uer_core
  import uer_pkg::*;
#(
  parameter int TIME_WIDTH = 32
)
(
  input  logic      clk,
  input  logic      rst_n,
  input  item_t     item,
  input  logic      upd,
  input  cfg_t      cfg,
  output step_res_t res
);

  localparam int CW = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;
  localparam int WW = (TIME_WIDTH > MEAS_W) ? TIME_WIDTH : MEAS_W;

  logic [TIME_WIDTH-1:0] accu_r, accu_nxt;
  logic [TIME_WIDTH-1:0] last_poll_r, last_poll_nxt;
  logic [TIME_WIDTH-1:0] echo_start_r, echo_start_nxt;
  logic                  started_r, started_nxt;
  logic                  finished_r, finished_nxt;
  logic                  new_r, new_nxt;

  logic [TIME_WIDTH-1:0] ts;
  logic [TIME_WIDTH-1:0] delta;
  logic [TIME_WIDTH:0]   sum_x;
  logic [TIME_WIDTH-1:0] accu_sum;
  logic [CW-1:0]         accu_c;
  logic                  timeout;
  logic                  step_ok;
  logic [TIME_WIDTH-1:0] width;
  logic [WW-1:0]         width_x;

  assign ts       = TIME_WIDTH'(item.ts);
  assign delta    = ts - last_poll_r;
  assign sum_x    = {1'b0, accu_r} + {1'b0, delta};
  // saturate on carry out
  assign accu_sum = sum_x[TIME_WIDTH] ? '1 : sum_x[TIME_WIDTH-1:0];
  assign accu_c   = CW'(accu_sum);
  assign timeout  = accu_c >= CW'(cfg.max_step_time);
  assign step_ok  = accu_c >= CW'(cfg.step_time);
  assign width    = ts - echo_start_r;
  assign width_x  = WW'(width);

  always_comb begin
    accu_nxt       = accu_r;
    last_poll_nxt  = last_poll_r;
    echo_start_nxt = echo_start_r;
    started_nxt    = started_r;
    finished_nxt   = finished_r;
    new_nxt        = new_r;

    res.trig         = 1'b0;
    res.drq.op       = DOP_KEEP;
    res.drq.load_val = cfg.max_distance;
    res.drq.meas_w   = width_x[MEAS_W-1:0];
    res.drq.sat      = width_x > WW'(WIDTH_LIMIT);

    if (item.kind == KIND_POLL) begin
      accu_nxt      = accu_sum;
      last_poll_nxt = ts;
      new_nxt       = 1'b0;
      if (timeout || (step_ok && finished_r)) begin
        if (timeout) begin
          res.drq.op = DOP_LOAD;
        end
        new_nxt        = 1'b1;
        res.trig       = 1'b1;
        accu_nxt       = '0;
        echo_start_nxt = '0;
        started_nxt    = 1'b0;
        finished_nxt   = 1'b0;
      end
    end else if (item.level) begin
      if (!started_r) begin
        started_nxt    = 1'b1;
        echo_start_nxt = ts;
        new_nxt        = 1'b0;
      end
    end else if (started_r && !finished_r) begin
      res.drq.op   = DOP_MEAS;
      finished_nxt = 1'b1;
      new_nxt      = 1'b1;
    end

    res.newf = new_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accu_r       <= '1;
      last_poll_r  <= '0;
      echo_start_r <= '0;
      started_r    <= 1'b0;
      finished_r   <= 1'b0;
      new_r        <= 1'b0;
    end else if (upd) begin
      accu_r       <= accu_nxt;
      last_poll_r  <= last_poll_nxt;
      echo_start_r <= echo_start_nxt;
      started_r    <= started_nxt;
      finished_r   <= finished_nxt;
      new_r        <= new_nxt;
    end
  end

endmodule

// ----- rtl/uer_scale.sv -----
module uer_scale
  import uer_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pipe_en_t          en,
  input  step_res_t         s2,
  output logic              trig,
  output logic              newf,
  output logic [DIST_W-1:0] distance
);

  logic [PROD_W-1:0] prod_r;
  dist_op_t          op_r;
  logic [DIST_W-1:0] load_r;
  logic              sat_r;
  logic              trig_mid_r;
  logic              newf_mid_r;

  logic              trig_r;
  logic              newf_r;
  logic [DIST_W-1:0] dist_r;

  logic [RPROD_W-1:0] rprod;
  logic [QUOT_W-1:0]  quot;
  logic [DIST_W-1:0]  meas_dist;
  logic [DIST_W-1:0]  dist_nxt;

  // scale the echo width, bias by half the divisor for rounding
  always_ff @(posedge clk) begin
    if (en.ld_mid) begin
      prod_r     <= PROD_W'(s2.drq.meas_w) * SCALE_NUM + SCALE_BIAS;
      op_r       <= s2.drq.op;
      load_r     <= s2.drq.load_val;
      sat_r      <= s2.drq.sat;
      trig_mid_r <= s2.trig;
      newf_mid_r <= s2.newf;
    end
  end

  // divide by 3125 through the reciprocal
  assign rprod = RPROD_W'(prod_r) * RPROD_W'(RECIP);
  assign quot  = rprod[RECIP_SHIFT +: QUOT_W];
  assign meas_dist = (sat_r || (quot > QUOT_W'(DIST_MAX))) ? DIST_MAX : quot[DIST_W-1:0];

  always_comb begin
    case (op_r)
      DOP_KEEP: dist_nxt = dist_r;
      DOP_LOAD: dist_nxt = load_r;
      DOP_MEAS: dist_nxt = meas_dist;
      default:  dist_nxt = dist_r;
    endcase
  end

  // the output register doubles as the distance state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_r <= DIST_RESET;
    end else if (en.ld_out) begin
      dist_r <= dist_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_out) begin
      trig_r <= trig_mid_r;
      newf_r <= newf_mid_r;
    end
  end

  assign trig     = trig_r;
  assign newf     = newf_r;
  assign distance = dist_r;

endmodule

// ----- rtl/ultrasonic_echo_ranger.sv -----
// Ultrasonic ranger timing engine.
// in_if carries one word per event: a poll (kind 0) with the current
// microsecond timestamp, or an echo pin edge (kind 1) with its new level.
// out_if returns exactly one word per input word, in order: trigger_pulse
// (start the trigger pulse now), has_new_distance and the latest distance
// in 1/256 cm. cfg_if writes step_time, max_step_time and max_distance by
// index; it is always ready, and the user must write it only while the
// block is idle: the block itself does not enforce this. Pipeline: input
// register, state update, width scaling multiply, then the reciprocal
// divide into the output register. One word is accepted per cycle while
// out_if is not stalled; the timer state update sets that rate.
// Each stage moves only when the stage after it is empty or moving, so
// words keep entering while a result waits; a full pipeline with out_if
// stalled drops in_if.ready. Reset empties the pipeline, loads default
// configuration, saturates the elapsed accumulator so the first poll
// triggers, and sets the distance to 102400.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int TIME_WIDTH = 32
)
(
  input  logic       clk,
  input  logic       rst_n,
  uer_in_if.sink     in_if,
  uer_out_if.source  out_if,
  uer_cfg_if.sink    cfg_if
);

  cfg_t      cfg;
  item_t     item_r;
  step_res_t res;
  step_res_t s2_r;
  pipe_en_t  pen;

  logic v1_r, v2_r, v3_r, vo_r;
  logic en1, en2, en3, en_o;

  assign en_o = !vo_r || out_if.ready;
  assign en3  = !v3_r || en_o;
  assign en2  = !v2_r || en3;
  assign en1  = !v1_r || en2;

  assign in_if.ready = en1;
  assign out_if.valid = vo_r;

  assign pen.ld_mid = en3;
  assign pen.ld_out = en_o && v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_if.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
      if (en_o) begin
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      item_r.kind  <= in_if.kind;
      item_r.ts    <= in_if.timestamp;
      item_r.level <= in_if.echo_level;
    end
    if (en2) begin
      s2_r <= res;
    end
  end

  uer_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // state advances only as a real word leaves the input register
  uer_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item_r),
    .upd   (v1_r && en2),
    .cfg   (cfg),
    .res   (res)
  );

  uer_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pen),
    .s2       (s2_r),
    .trig     (out_if.trigger_pulse),
    .newf     (out_if.has_new_distance),
    .distance (out_if.distance)
  );

endmodule

// ----- rtl/uer_checker.sv -----
`include "ultrasonic_echo_ranger_macros.svh"

module uer_checker
  import uer_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_trigger_pulse,
  input logic              out_has_new_distance,
  input logic [DIST_W-1:0] out_distance
);

  // every retrigger reports, either a timeout or a finished echo
  `UER_ASSERT_IMP(a_trig_reports, clk, rst_n, out_valid && out_trigger_pulse, out_has_new_distance)

  `UER_ASSERT_NXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_trigger_pulse) && $stable(out_has_new_distance) && $stable(out_distance))

  // reset flushes the pipeline
  `UER_ASSERT_RST(a_reset_flush, clk, rst_n, !out_valid)

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_if.valid),
  .out_ready            (out_if.ready),
  .out_trigger_pulse    (out_if.trigger_pulse),
  .out_has_new_distance (out_if.has_new_distance),
  .out_distance         (out_if.distance)
);
